FILE: src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: request and
// result beats, request and status codes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    REQ_INS_END   = 3'd0,
    REQ_INS_BEGIN = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_UPD_POS   = 3'd3,
    REQ_DEL_BEGIN = 3'd4,
    REQ_DEL_END   = 3'd5,
    REQ_DEL_POS   = 3'd6,
    REQ_READOUT   = 3'd7
  } req_code_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INS,
    OP_UPD,
    OP_DEL,
    OP_ROT
  } op_e;

  typedef enum logic [1:0] {
    SEL_END,
    SEL_BEGIN,
    SEL_POS
  } sel_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [POS_W-1:0]   position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [5:0]         list_length;
    logic               last_flag;
  } res_t;

  typedef struct packed {
    op_e     op;
    sel_e    sel;
    status_e status;
    logic    emit;
    logic    emit_value;
    logic    last;
    logic    load_rem;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic ins_pos_ok;
    logic pos_ok;
    logic cnt_is_one;
    logic rem_is_one;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Request decoder and readout sequencer. Checks each request against the
// datapath status and issues one command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] req_type_i,
  input  dp_status_t dp_status_i,
  output logic       busy,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    busy           = (state_q == S_READ);
    cmd_o          = '0;
    cmd_o.op       = OP_NOP;
    cmd_o.sel      = SEL_POS;
    cmd_o.status   = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          case (req_type_i)
            REQ_INS_END, REQ_INS_BEGIN, REQ_INS_POS: begin
              if (dp_status_i.full) begin
                cmd_o.status = ST_FULL;
              end else if (req_type_i == REQ_INS_POS && !dp_status_i.ins_pos_ok) begin
                cmd_o.status = ST_BADPOS;
              end else begin
                cmd_o.op  = OP_INS;
                cmd_o.sel = (req_type_i == REQ_INS_END)   ? SEL_END :
                            (req_type_i == REQ_INS_BEGIN) ? SEL_BEGIN : SEL_POS;
              end
            end
            REQ_UPD_POS: begin
              if (!dp_status_i.pos_ok) begin
                cmd_o.status = ST_BADPOS;
              end else begin
                cmd_o.op = OP_UPD;
              end
            end
            REQ_DEL_BEGIN, REQ_DEL_END, REQ_DEL_POS: begin
              if (dp_status_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else if (req_type_i == REQ_DEL_POS && !dp_status_i.pos_ok) begin
                cmd_o.status = ST_BADPOS;
              end else begin
                cmd_o.op  = OP_DEL;
                cmd_o.sel = (req_type_i == REQ_DEL_END)   ? SEL_END :
                            (req_type_i == REQ_DEL_BEGIN) ? SEL_BEGIN : SEL_POS;
              end
            end
            default: begin
              if (dp_status_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else begin
                // emit the head and rotate; stay for the rest of the list
                cmd_o.op         = OP_ROT;
                cmd_o.emit_value = 1'b1;
                cmd_o.load_rem   = 1'b1;
                cmd_o.last       = dp_status_i.cnt_is_one;
                if (!dp_status_i.cnt_is_one) begin
                  state_d = S_READ;
                end
              end
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.op         = OP_ROT;
        cmd_o.emit       = 1'b1;
        cmd_o.emit_value = 1'b1;
        cmd_o.last       = dp_status_i.rem_is_one;
        if (dp_status_i.rem_is_one) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// Row of shifting cells holding the list, element count, readout counter and
// the registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_dp
  import ple_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic signed [31:0] item_value_i,
  output dp_status_t         dp_status_o,
  output logic               result_valid_o,
  output res_t               result_o
);

  logic signed [31:0] cell_q [CAPACITY];
  logic signed [31:0] cell_d [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   idx;
  logic [CMP_W-1:0]   pos_x, cnt_x;
  logic               res_valid_q;
  res_t               res_q;

  assign pos_x = CMP_W'(position_i);
  assign cnt_x = CMP_W'(count_q);

  assign dp_status_o.empty      = (count_q == '0);
  assign dp_status_o.full       = (count_q == CNT_W'(CAPACITY));
  assign dp_status_o.ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign dp_status_o.pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
  assign dp_status_o.cnt_is_one = (count_q == CNT_W'(1));
  assign dp_status_o.rem_is_one = (rem_q == CNT_W'(1));

  // target cell index: end means the free slot for insert, the tail for delete
  always_comb begin
    case (cmd_i.sel)
      SEL_END:   idx = (cmd_i.op == OP_INS) ? count_q : count_q - CNT_W'(1);
      SEL_BEGIN: idx = '0;
      SEL_POS:   idx = CNT_W'(pos_x - CMP_W'(1));
      default:   idx = '0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    rem_d   = rem_q;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
    end

    case (cmd_i.op)
      OP_INS: begin
        count_d = count_q + CNT_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == idx) begin
            cell_d[i] = item_value_i;
          end else if (i > 0 && CNT_W'(i) > idx && CNT_W'(i) <= count_q) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
      OP_UPD: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == idx) begin
            cell_d[i] = item_value_i;
          end
        end
      end
      OP_DEL: begin
        count_d = count_q - CNT_W'(1);
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (CNT_W'(i) >= idx && CNT_W'(i + 1) < count_q) begin
            cell_d[i] = cell_q[i + 1];
          end
        end
      end
      OP_ROT: begin
        // rotate the held elements left by one; head wraps to the tail
        rem_d = cmd_i.load_rem ? count_q - CNT_W'(1) : rem_q - CNT_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i + 1) == count_q) begin
            cell_d[i] = cell_q[0];
          end else if (i < CAPACITY - 1 && CNT_W'(i + 1) < count_q) begin
            cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rem_q       <= rem_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.status      <= cmd_i.status;
      res_q.read_value  <= cmd_i.emit_value ? cell_q[0] : 32'sd0;
      res_q.list_length <= 6'(count_d);
      res_q.last_flag   <= cmd_i.last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

FILE: src/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values with positional insert, update,
// delete and in-order readout, held in a row of shifting cells.
// ----------------------------------------------------------------------------
//
//   channel   | handshake              | beat
//   ----------+------------------------+---------------------------
//   request   | start high, busy low   | req_i  (req_t)
//   result    | result_valid_o strobe  | result_o (res_t)
//
// Every request except a readout of a non-empty list yields one result beat in
// the next cycle; such requests may run every cycle.
// A readout of N >= 1 elements yields N beats on consecutive cycles and holds
// busy high until its last beat is issued: the cell row rotates by one position per cycle.
// Reset clears the element count; the cells are undefined until written.
// Result beats are not held: each stands for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_core
  import ple_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output res_t result_o
);

  cmd_t       cmd;
  dp_status_t dp_status;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_type_i  (req_i.req_type),
    .dp_status_i (dp_status),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  ple_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .position_i     (req_i.position),
    .item_value_i   (req_i.item_value),
    .dp_status_o    (dp_status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/positional_list_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb
// Self-checking bench for the positional list engine. A driver feeds request
// beats from a pending queue under random gaps; a shadow list predicts every
// result beat; a monitor checks each strobed beat against the oldest
// prediction. Directed corner requests come first, then random phases that
// fill the list to capacity, run back to back, drain it and mix freely.
// ----------------------------------------------------------------------------

module positional_list_engine_core_tb;
  import ple_pkg::*;

  typedef struct {
    req_t rq;
    bit   gap_ok;
    bit   drain;
  } pending_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_valid_o;
  res_t result_o;

  pending_item_t pending_reqs[$];
  res_t          expected_beats[$];

  // shadow of the list contents, advanced on every accepted request
  logic signed [31:0] list_cells[CAPACITY];
  int                 list_count = 0;

  int errors = 0;
  int gen_len = 0;
  int n_random = 0;

  bit            drv_accept;
  bit            drv_start;
  req_t          drv_req;
  pending_item_t drv_item;

  positional_list_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Apply one accepted request to the shadow list and queue its result beats.
  task automatic apply_request(input req_t rq);
    res_t       beat;
    int         idx;
    logic [1:0] st;
    bit         listing;
    beat = '0;
    st = ST_OK;
    idx = -1;
    listing = 1'b0;
    case (req_code_e'(rq.req_type))
      REQ_INS_END, REQ_INS_BEGIN, REQ_INS_POS: begin
        if (list_count >= CAPACITY) st = ST_FULL;
        else if (rq.req_type == REQ_INS_END) idx = list_count;
        else if (rq.req_type == REQ_INS_BEGIN) idx = 0;
        else if (rq.position < 1 || rq.position > list_count + 1) st = ST_BADPOS;
        else idx = rq.position - 1;
        if (idx >= 0) begin
          for (int i = list_count; i > idx; i--) list_cells[i] = list_cells[i-1];
          list_cells[idx] = rq.item_value;
          list_count++;
        end
      end
      REQ_UPD_POS: begin
        if (rq.position < 1 || rq.position > list_count) st = ST_BADPOS;
        else list_cells[rq.position-1] = rq.item_value;
      end
      REQ_DEL_BEGIN, REQ_DEL_END, REQ_DEL_POS: begin
        if (list_count == 0) st = ST_EMPTY;
        else if (rq.req_type == REQ_DEL_BEGIN) idx = 0;
        else if (rq.req_type == REQ_DEL_END) idx = list_count - 1;
        else if (rq.position < 1 || rq.position > list_count) st = ST_BADPOS;
        else idx = rq.position - 1;
        if (idx >= 0) begin
          for (int i = idx; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
          list_count--;
        end
      end
      default: begin
        if (list_count == 0) st = ST_EMPTY;
        else listing = 1'b1;
      end
    endcase
    if (listing) begin
      for (int i = 0; i < list_count; i++) begin
        beat.status      = ST_OK;
        beat.read_value  = list_cells[i];
        beat.list_length = list_count[5:0];
        beat.last_flag   = (i == list_count - 1);
        expected_beats.push_back(beat);
      end
    end else begin
      beat.status      = st;
      beat.read_value  = '0;
      beat.list_length = list_count[5:0];
      beat.last_flag   = 1'b1;
      expected_beats.push_back(beat);
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Queue a request and track the list length it leaves, to aim positions.
  task automatic queue_item(input req_t rq, input bit gap_ok, input bit drain);
    pending_item_t it;
    it.rq = rq;
    it.gap_ok = gap_ok;
    it.drain = drain;
    pending_reqs.push_back(it);
    case (req_code_e'(rq.req_type))
      REQ_INS_END, REQ_INS_BEGIN:
        if (gen_len < CAPACITY) gen_len++;
      REQ_INS_POS:
        if (gen_len < CAPACITY && rq.position >= 1 && rq.position <= gen_len + 1) gen_len++;
      REQ_DEL_BEGIN, REQ_DEL_END:
        if (gen_len > 0) gen_len--;
      REQ_DEL_POS:
        if (gen_len > 0 && rq.position >= 1 && rq.position <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic queue_directed(input req_code_e code, input int pos, input logic [31:0] val);
    req_t rq;
    rq.req_type   = code;
    rq.position   = pos[5:0];
    rq.item_value = val;
    queue_item(rq, 1'b1, 1'b0);
  endtask

  task automatic queue_random(input int ins_w, input int del_w, input bit gap_ok,
                              input bit drain);
    req_t rq;
    int   r;
    int   lim;
    r = $urandom_range(0, 99);
    if (r < ins_w) rq.req_type = 3'($urandom_range(0, 2));
    else if (r < ins_w + del_w) rq.req_type = 3'($urandom_range(4, 6));
    else if (r < ins_w + del_w + 8) rq.req_type = REQ_READOUT;
    else rq.req_type = REQ_UPD_POS;
    lim = (rq.req_type == REQ_INS_POS) ? gen_len + 1 : gen_len;
    if (lim > 0 && $urandom_range(0, 99) < 80) rq.position = 6'($urandom_range(1, lim));
    else rq.position = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0:       rq.item_value = 32'h7fff_ffff;
      1:       rq.item_value = 32'h8000_0000;
      2:       rq.item_value = 32'hffff_ffff;
      3:       rq.item_value = '0;
      default: rq.item_value = $urandom;
    endcase
    queue_item(rq, gap_ok, drain);
    n_random++;
  endtask

  // Driver: retire the beat accepted at this edge, then present the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      drv_accept = start && !busy;
      if (drv_accept) apply_request(req_i);
      drv_start = start && !drv_accept;
      drv_req = req_i;
      if (!drv_start && pending_reqs.size() > 0) begin
        // hold the drain beat until no result is outstanding
        if (pending_reqs[0].drain && (expected_beats.size() > 0 || result_valid_o)) begin
          drv_start = 1'b0;
        end else if (pending_reqs[0].gap_ok && $urandom_range(0, 99) < 15) begin
          drv_start = 1'b0;
        end else begin
          drv_start = 1'b1;
          drv_item = pending_reqs.pop_front();
          drv_req = drv_item.rq;
        end
      end
      start <= drv_start;
      req_i <= drv_req;
    end
  end

  // Monitor: every strobed beat must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none actual status %0d value %0d",
                 $time, result_o.status, result_o.read_value);
        errors++;
      end else begin
        res_t want;
        want = expected_beats.pop_front();
        check_field("status", want.status, result_o.status);
        check_field("read_value", want.read_value, result_o.read_value);
        check_field("list_length", want.list_length, result_o.list_length);
        check_field("last_flag", want.last_flag, result_o.last_flag);
      end
    end
  end

  initial begin
    int guard;
    rst_ni = 1'b0;

    // corner requests on an empty list, then a short list
    queue_directed(REQ_READOUT, 0, '0);
    queue_directed(REQ_DEL_BEGIN, 0, '0);
    queue_directed(REQ_DEL_END, 0, '0);
    queue_directed(REQ_DEL_POS, 1, '0);
    queue_directed(REQ_UPD_POS, 1, 32'h1234_5678);
    queue_directed(REQ_INS_POS, 0, 32'h1111_1111);
    queue_directed(REQ_INS_POS, 2, 32'h2222_2222);
    queue_directed(REQ_INS_END, 0, 32'h7fff_ffff);
    queue_directed(REQ_INS_BEGIN, 63, 32'h8000_0000);
    queue_directed(REQ_INS_POS, 3, 32'hffff_ffff);
    queue_directed(REQ_INS_POS, 2, 32'h0000_0000);
    queue_directed(REQ_INS_POS, 63, 32'h3333_3333);
    queue_directed(REQ_UPD_POS, 0, 32'h4444_4444);
    queue_directed(REQ_UPD_POS, 5, 32'h4444_4444);
    queue_directed(REQ_UPD_POS, 4, 32'h5555_5555);
    queue_directed(REQ_UPD_POS, 1, 32'haaaa_aaaa);
    queue_directed(REQ_READOUT, 0, '0);
    queue_directed(REQ_DEL_POS, 0, '0);
    queue_directed(REQ_DEL_POS, 5, '0);
    queue_directed(REQ_DEL_POS, 2, '0);
    queue_directed(REQ_DEL_BEGIN, 0, '0);
    queue_directed(REQ_DEL_END, 0, '0);
    queue_directed(REQ_READOUT, 0, '0);
    queue_directed(REQ_DEL_END, 0, '0);
    queue_directed(REQ_READOUT, 0, '0);

    // grow to capacity, then push against the full store
    guard = 0;
    while (gen_len < CAPACITY && guard < 120) begin
      queue_random(85, 5, 1'b1, 1'b0);
      guard++;
    end
    repeat (8) queue_random(70, 0, 1'b1, 1'b0);

    // back-to-back stretch with no gaps
    repeat (40) queue_random(35, 35, 1'b0, 1'b0);

    // drain to empty, starting from a quiet engine
    queue_random(0, 90, 1'b1, 1'b1);
    guard = 0;
    while (gen_len > 0 && guard < 120) begin
      queue_random(5, 85, 1'b1, 1'b0);
      guard++;
    end
    repeat (4) queue_random(0, 90, 1'b1, 1'b0);

    while (n_random < 145) queue_random(40, 35, 1'b1, 1'b0);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() > 0 || start || expected_beats.size() > 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (expected_beats.size() > 0) begin
      $display("%0t ns: %0d result beats never arrived", $time, expected_beats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("positional_list_engine_core regression: pass");
    end else begin
      $display("positional_list_engine_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("positional_list_engine_core regression: fail");
    $finish;
  end

endmodule
